// ----- src/ppm_hdr_pkg.sv -----
// ppm_hdr_pkg: shared types and character constants for the ppm p6 header parser
// no dependencies; used by the result channel interface, the top level and the bench

package ppm_hdr_pkg;

    // character codes seen in a header
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_SIX   = 8'h36;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // numeric limits of the format
    localparam int unsigned MIN_HEADER  = 8;
    localparam logic [19:0] NUM_LIMIT   = 20'd65535;
    localparam logic [15:0] WANT_MAXVAL = 16'd255;
    localparam int unsigned NUM_COUNT   = 3;

    // widths of the word fields
    localparam int unsigned DIM_W = 16;
    localparam int unsigned OFS_W = 7;

    // one result word
    typedef struct packed {
        logic             header_ok;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [OFS_W-1:0] pixel_offset;
    } t_result;

endpackage

// ----- src/ppm_hdr_in_if.sv -----
// ppm_hdr_in_if: input channel carrying one header byte per word
// depends on nothing outside this file

interface ppm_hdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// ----- src/ppm_hdr_out_if.sv -----
// ppm_hdr_out_if: result channel carrying one header decision per word
// depends on ppm_hdr_pkg for the field widths

interface ppm_hdr_out_if;
    logic                           valid;
    logic                           ready;
    logic                           header_ok;
    logic [ppm_hdr_pkg::DIM_W-1:0]  image_width;
    logic [ppm_hdr_pkg::DIM_W-1:0]  image_height;
    logic [ppm_hdr_pkg::OFS_W-1:0]  pixel_offset;

    modport source (output valid, output header_ok, output image_width,
                    output image_height, output pixel_offset, input ready);
    modport sink   (input valid, input header_ok, input image_width,
                    input image_height, input pixel_offset, output ready);
endinterface

// ----- src/ppm_p6_header_parser_top.sv -----
// ppm_p6_header_parser_top: binary ppm (p6) header parser, one byte per word
// depends on ppm_hdr_pkg, ppm_hdr_in_if and ppm_hdr_out_if
//
//  channel  | direction | word contents
//  ---------+-----------+-----------------------------------------------------
//  i_byte   | in        | data_byte, first_byte
//  o_hdr    | out       | header_ok, image_width, image_height, pixel_offset
//
// one byte is taken every cycle while the skid entry is free; a decision is
// registered into the result register (or the skid entry behind a held result)
// and leaves through o_hdr; this two-entry result buffer lets bytes keep flowing
// while a result waits; i_byte stalls only when both entries are held
// synchronous active-low reset leaves the parser idle until a first_byte word

module ppm_p6_header_parser_top #(
    parameter int unsigned HEADER_LEN = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ppm_hdr_in_if.sink           i_byte,
    ppm_hdr_out_if.source        o_hdr
);

    localparam int unsigned POS_CLOG = $clog2(HEADER_LEN + 1);
    localparam int unsigned POS_W    = (POS_CLOG > ppm_hdr_pkg::OFS_W) ?
                                       POS_CLOG : ppm_hdr_pkg::OFS_W;
    localparam logic [POS_W:0] HDR_LEN_V = (POS_W + 1)'(HEADER_LEN);
    localparam logic           SHORT_LEN = (HEADER_LEN < ppm_hdr_pkg::MIN_HEADER);

    // parse state
    logic [POS_W-1:0]               r_pos,     n_pos;
    logic [ppm_hdr_pkg::DIM_W-1:0]  r_num [ppm_hdr_pkg::NUM_COUNT];
    logic [ppm_hdr_pkg::DIM_W-1:0]  n_num [ppm_hdr_pkg::NUM_COUNT];
    logic [1:0]                     r_idx,     n_idx;
    logic                           r_in_num,  n_in_num;
    logic                           r_decided, n_decided;

    // result buffer
    logic                           r_out_valid, r_skid_valid;
    ppm_hdr_pkg::t_result           r_out, r_skid;

    logic                           accept;
    logic                           emit;
    ppm_hdr_pkg::t_result           res;

    // state as seen by the current byte, after a restart if first_byte is set
    logic [POS_W-1:0]               cur_pos;
    logic [ppm_hdr_pkg::DIM_W-1:0]  cur_num [ppm_hdr_pkg::NUM_COUNT];
    logic [1:0]                     cur_idx;
    logic                           cur_in_num;
    logic                           cur_decided;

    logic [POS_W:0]                 pos_inc;
    logic [ppm_hdr_pkg::DIM_W-1:0]  sel_num;
    logic [19:0]                    acc;
    logic [1:0]                     idx_inc;
    logic [7:0]                     c;
    logic                           is_digit;
    logic                           is_sep;

    assign accept         = i_byte.valid && i_byte.ready;
    assign i_byte.ready   = !r_skid_valid;
    assign c              = i_byte.data_byte;

    // restart view of the state
    always_comb begin
        cur_pos     = i_byte.first_byte ? '0   : r_pos;
        cur_idx     = i_byte.first_byte ? 2'd0 : r_idx;
        cur_in_num  = i_byte.first_byte ? 1'b0 : r_in_num;
        cur_decided = i_byte.first_byte ? 1'b0 : r_decided;
        for (int i = 0; i < ppm_hdr_pkg::NUM_COUNT; i++) begin
            cur_num[i] = i_byte.first_byte ? '0 : r_num[i];
        end
    end

    // character classes and the multiply-by-ten accumulate
    always_comb begin
        is_digit = (c >= ppm_hdr_pkg::CHAR_ZERO) && (c <= ppm_hdr_pkg::CHAR_NINE);
        is_sep   = (c == ppm_hdr_pkg::CHAR_SPACE) || (c == ppm_hdr_pkg::CHAR_TAB) ||
                   (c == ppm_hdr_pkg::CHAR_CR) || (c == ppm_hdr_pkg::CHAR_LF);
        unique case (cur_idx)
            2'd0:    sel_num = cur_num[0];
            2'd1:    sel_num = cur_num[1];
            2'd2:    sel_num = cur_num[2];
            default: sel_num = '0;
        endcase
        acc     = ({4'b0, sel_num} << 3) + ({4'b0, sel_num} << 1) +
                  {12'b0, c - ppm_hdr_pkg::CHAR_ZERO};
        pos_inc = {1'b0, cur_pos} + (POS_W + 1)'(1);
        idx_inc = cur_idx + 2'd1;
    end

    // per-byte parse step
    always_comb begin
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_in_num  = r_in_num;
        n_decided = r_decided;
        for (int i = 0; i < ppm_hdr_pkg::NUM_COUNT; i++) begin
            n_num[i] = r_num[i];
        end
        emit = 1'b0;
        res  = '0;

        if (accept && !cur_decided) begin
            n_pos     = pos_inc[POS_W-1:0];
            n_idx     = cur_idx;
            n_in_num  = cur_in_num;
            n_decided = 1'b0;
            for (int i = 0; i < ppm_hdr_pkg::NUM_COUNT; i++) begin
                n_num[i] = cur_num[i];
            end

            priority if (cur_pos == '0) begin
                // magic, first letter
                if (SHORT_LEN || c != ppm_hdr_pkg::CHAR_P) begin
                    emit = 1'b1;
                end
            end else if (cur_pos == POS_W'(1)) begin
                // magic, digit six
                if (c != ppm_hdr_pkg::CHAR_SIX) begin
                    emit = 1'b1;
                end
            end else if (is_digit) begin
                if (cur_idx == 2'd3 || acc > ppm_hdr_pkg::NUM_LIMIT) begin
                    emit = 1'b1;
                end else begin
                    for (int i = 0; i < ppm_hdr_pkg::NUM_COUNT; i++) begin
                        if (cur_idx == 2'(i)) begin
                            n_num[i] = acc[ppm_hdr_pkg::DIM_W-1:0];
                        end
                    end
                    n_in_num = 1'b1;
                end
            end else if (is_sep) begin
                // a separator closes a number; the third one decides
                if (cur_in_num) begin
                    n_in_num = 1'b0;
                    n_idx    = idx_inc;
                    if (idx_inc == 2'd3) begin
                        emit             = 1'b1;
                        res.header_ok    = (cur_num[2] == ppm_hdr_pkg::WANT_MAXVAL) &&
                                           (cur_num[0] != '0) && (cur_num[1] != '0);
                        res.image_width  = cur_num[0];
                        res.image_height = cur_num[1];
                        res.pixel_offset = pos_inc[ppm_hdr_pkg::OFS_W-1:0];
                    end
                end
            end else begin
                emit = 1'b1;
            end

            // length limit reached without a decision
            if (!emit && pos_inc >= HDR_LEN_V) begin
                emit = 1'b1;
            end

            if (emit) begin
                n_decided = 1'b1;
            end
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_idx     <= 2'd0;
            r_in_num  <= 1'b0;
            r_decided <= 1'b1;
            for (int i = 0; i < ppm_hdr_pkg::NUM_COUNT; i++) begin
                r_num[i] <= '0;
            end
        end else begin
            r_pos     <= n_pos;
            r_idx     <= n_idx;
            r_in_num  <= n_in_num;
            r_decided <= n_decided;
            for (int i = 0; i < ppm_hdr_pkg::NUM_COUNT; i++) begin
                r_num[i] <= n_num[i];
            end
        end
    end

    // result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !o_hdr.ready) begin
            if (emit) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= emit;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_out_valid && !o_hdr.ready) begin
            if (emit) begin
                r_skid <= res;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (emit) begin
            r_out <= res;
        end
    end

    assign o_hdr.valid        = r_out_valid;
    assign o_hdr.header_ok    = r_out.header_ok;
    assign o_hdr.image_width  = r_out.image_width;
    assign o_hdr.image_height = r_out.image_height;
    assign o_hdr.pixel_offset = r_out.pixel_offset;

    // skid entry is only used behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in the output register");

    // a decision always leaves the parser idle
    a_emit_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_decided)
        else $error("parser not idle after a decision");

    // position never runs past the header length
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_decided |-> ({1'b0, r_pos} < HDR_LEN_V))
        else $error("byte position beyond header length while parsing");

    // all three numbers done only once decided
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_decided |-> (r_idx != 2'd3))
        else $error("third number closed without a decision");

endmodule

// ----- tb/ppm_p6_header_parser_top_tb.sv -----
`timescale 1ns / 100ps
// ppm_p6_header_parser_top_tb: self-checking bench for the ppm p6 header parser
// depends on ppm_hdr_pkg, ppm_hdr_in_if, ppm_hdr_out_if and ppm_p6_header_parser_top

module ppm_p6_header_parser_top_tb;

    localparam int unsigned HEADER_LEN   = 64;
    localparam int unsigned SENT_TARGET  = 1800;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int          DIR_ROWS     = 23;

    // one directed header: text, spaces inserted after the magic, optional last word
    typedef struct {
        string                text;
        int                   pad;
        int                   tail;
        bit                   start;
        bit                   typed;
        ppm_hdr_pkg::t_result want;
    } t_hdr_case;

    logic i_clk;
    logic i_rst_n;

    ppm_hdr_in_if  byte_if ();
    ppm_hdr_out_if hdr_if ();

    ppm_p6_header_parser_top #(
        .HEADER_LEN(HEADER_LEN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_hdr   (hdr_if)
    );

    // header parse state as the parser should hold it
    int unsigned hp_pos;
    int unsigned hp_val [3];
    int unsigned hp_count;
    bit          hp_in_digits;
    bit          hp_decided = 1'b1;

    ppm_hdr_pkg::t_result hdr_expect_q [$];
    int unsigned sent_bytes;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int          src_idle_pct  = 27;
    int          sink_idle_pct = 51;

    t_hdr_case dir_cases [DIR_ROWS] = '{
        // idle after reset: no first flag, nothing happens
        '{"P6 1 1 255\n",           0, -1, 1'b0, 1'b0, '0},
        '{"P6 1 1 255\n",           0, -1, 1'b1, 1'b1, '{1'b1, 16'd1, 16'd1, 7'd11}},
        '{"P6 65535 65535 255 ",    0, -1, 1'b1, 1'b1, '{1'b1, 16'd65535, 16'd65535, 7'd19}},
        // number over the limit
        '{"P6 65536 1 255\n",       0, -1, 1'b1, 1'b1, '0},
        // bad magic, second and first byte
        '{"P5 1 1 255\n",           0, -1, 1'b1, 1'b1, '0},
        '{"Q6 1 1 255\n",           0, -1, 1'b1, 1'b1, '0},
        // runs of mixed separators
        '{"P6\t\t 640\015\n480\n255\015", 0, -1, 1'b1, 1'b0, '0},
        // zero dimension or bad maxval keep the parsed values
        '{"P6 0 5 255\n",           0, -1, 1'b1, 1'b1, '{1'b0, 16'd0, 16'd5, 7'd11}},
        '{"P6 5 0 255 ",            0, -1, 1'b1, 1'b1, '{1'b0, 16'd5, 16'd0, 7'd11}},
        '{"P6 5 5 256\n",           0, -1, 1'b1, 1'b1, '{1'b0, 16'd5, 16'd5, 7'd11}},
        // words after the decision are ignored
        '{"P6 3 4 255\nP6 9 9",     0, -1, 1'b1, 1'b0, '0},
        // cut short, the next header restarts the parse
        '{"P6 12 ",                 0, -1, 1'b1, 1'b0, '0},
        '{"P6 7 8 255\n",           0, -1, 1'b1, 1'b1, '{1'b1, 16'd7, 16'd8, 7'd11}},
        // bad character inside a number
        '{"P6 1 1 25x",             0, -1, 1'b1, 1'b1, '0},
        // length reached with no decision
        '{"P6",                    62, -1, 1'b1, 1'b1, '0},
        // decision on the very last byte allowed
        '{"P6 1 1 255\n",          53, -1, 1'b1, 1'b1, '{1'b1, 16'd1, 16'd1, 7'd64}},
        '{"P6 1 1 2555",           53, -1, 1'b1, 1'b0, '0},
        '{"P6 00010\n\n020 0255\t", 0, -1, 1'b1, 1'b0, '0},
        // data byte extremes
        '{"P6",                     0, 255, 1'b1, 1'b1, '0},
        '{"",                       0,   0, 1'b1, 1'b1, '0},
        '{"P6 1 2 255",             0,   0, 1'b1, 1'b1, '0},
        '{"P6 99999 1 255\n",       0, -1, 1'b1, 1'b1, '0},
        // first number straight after the magic
        '{"P66 7 255\n",            0, -1, 1'b1, 1'b0, '0}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // header parse of one byte; returns 1 when the byte decides the header
    function automatic bit parse_header_byte(input logic [7:0] c, input logic first,
                                             output ppm_hdr_pkg::t_result res);
        longint unsigned at;
        int unsigned     k;
        int unsigned     v;
        bit              fail;
        res  = '0;
        fail = 1'b0;
        if (first) begin
            hp_pos       = 0;
            hp_val       = '{0, 0, 0};
            hp_count     = 0;
            hp_in_digits = 1'b0;
            hp_decided   = 1'b0;
        end
        if (hp_decided)
            return 1'b0;
        at   = hp_pos;
        if (hp_pos != 32'hFFFF_FFFF)
            hp_pos = hp_pos + 1;
        if (at == 0) begin
            fail = (HEADER_LEN < ppm_hdr_pkg::MIN_HEADER) || (c != ppm_hdr_pkg::CHAR_P);
        end else if (at == 1) begin
            fail = (c != ppm_hdr_pkg::CHAR_SIX);
        end else if (c >= ppm_hdr_pkg::CHAR_ZERO && c <= ppm_hdr_pkg::CHAR_NINE) begin
            k = hp_count & 3;
            if (k > 2) begin
                fail = 1'b1;
            end else begin
                v = hp_val[k] * 10 + (c - ppm_hdr_pkg::CHAR_ZERO);
                if (v > ppm_hdr_pkg::NUM_LIMIT) begin
                    fail = 1'b1;
                end else begin
                    hp_val[k]    = v;
                    hp_in_digits = 1'b1;
                end
            end
        end else if (c == ppm_hdr_pkg::CHAR_SPACE || c == ppm_hdr_pkg::CHAR_TAB ||
                     c == ppm_hdr_pkg::CHAR_CR || c == ppm_hdr_pkg::CHAR_LF) begin
            if (hp_in_digits) begin
                hp_in_digits = 1'b0;
                hp_count++;
                // third separator decides the header
                if (hp_count >= ppm_hdr_pkg::NUM_COUNT) begin
                    res.header_ok    = (hp_val[2] == ppm_hdr_pkg::WANT_MAXVAL) &&
                                       (hp_val[0] != 0) && (hp_val[1] != 0);
                    res.image_width  = 16'(hp_val[0]);
                    res.image_height = 16'(hp_val[1]);
                    res.pixel_offset = 7'(at + 1);
                    hp_decided       = 1'b1;
                    return 1'b1;
                end
            end
        end else begin
            fail = 1'b1;
        end
        if (fail || (at + 1 >= HEADER_LEN)) begin
            res        = '0;
            hp_decided = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // send one word, with random idle cycles in front, and log its expectation
    task automatic put_byte(input logic [7:0] d, input logic first,
                            input bit typed, input ppm_hdr_pkg::t_result want);
        ppm_hdr_pkg::t_result res;
        while ($urandom_range(99) < src_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid      <= 1'b1;
        byte_if.data_byte  <= d;
        byte_if.first_byte <= first;
        do @(posedge i_clk); while (!byte_if.ready);
        if (parse_header_byte(d, first, res))
            hdr_expect_q.push_back(typed ? want : res);
        sent_bytes++;
    endtask

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(3))
            0:       return ppm_hdr_pkg::CHAR_SPACE;
            1:       return ppm_hdr_pkg::CHAR_TAB;
            2:       return ppm_hdr_pkg::CHAR_CR;
            default: return ppm_hdr_pkg::CHAR_LF;
        endcase
    endfunction

    // one mostly well-formed header with random content, sometimes broken
    task automatic send_random_header();
        logic [7:0]  hb [$];
        string       digits;
        int unsigned v;
        int unsigned cut;
        hb = {};
        case ($urandom_range(19))
            0: begin
                hb.push_back(8'($urandom_range(255)));
                hb.push_back(ppm_hdr_pkg::CHAR_SIX);
            end
            1: begin
                hb.push_back(ppm_hdr_pkg::CHAR_P);
                hb.push_back(8'($urandom_range(255)));
            end
            default: begin
                hb.push_back(ppm_hdr_pkg::CHAR_P);
                hb.push_back(ppm_hdr_pkg::CHAR_SIX);
            end
        endcase
        for (int n = 0; n < 3; n++) begin
            // separator run, now and then long enough to reach the length limit
            if ($urandom_range(15) == 0)
                repeat ($urandom_range(40, 60)) hb.push_back(ppm_hdr_pkg::CHAR_SPACE);
            else
                repeat ($urandom_range(n == 0 ? 0 : 1, 3)) hb.push_back(pick_sep());
            case ($urandom_range(9))
                0:       v = 0;
                1:       v = 65535;
                2:       v = $urandom_range(65536, 99999);
                3, 4, 5: v = $urandom_range(1, 20);
                6, 7:    v = $urandom_range(1, 65535);
                default: v = $urandom_range(1, 999);
            endcase
            if (n == 2 && $urandom_range(4) != 0)
                v = ppm_hdr_pkg::WANT_MAXVAL;
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(1, 2)) hb.push_back(ppm_hdr_pkg::CHAR_ZERO);
            digits = $sformatf("%0d", v);
            for (int i = 0; i < digits.len(); i++)
                hb.push_back(digits[i]);
        end
        hb.push_back(pick_sep());
        // corrupt one byte
        if ($urandom_range(5) == 0)
            hb[$urandom_range(hb.size() - 1)] = 8'($urandom_range(255));
        // cut short so the next header restarts mid-parse
        if ($urandom_range(11) == 0) begin
            cut = $urandom_range(hb.size() - 1);
            hb  = hb[0:cut];
        end
        // trailing bytes, ignored once decided
        if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 4)) hb.push_back(8'($urandom_range(255)));
        foreach (hb[i])
            put_byte(hb[i], i == 0, 1'b0, '0);
    endtask

    // result sink with random stalls
    always @(posedge i_clk) begin
        hdr_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        ppm_hdr_pkg::t_result want;
        if (i_rst_n && hdr_if.valid && hdr_if.ready) begin
            if (hdr_expect_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got ok=%0d w=%0d h=%0d off=%0d",
                         $time, hdr_if.header_ok, hdr_if.image_width, hdr_if.image_height,
                         hdr_if.pixel_offset);
                mismatches++;
            end else begin
                want = hdr_expect_q.pop_front();
                check_field("header_ok", want.header_ok, hdr_if.header_ok);
                check_field("image_width", want.image_width, hdr_if.image_width);
                check_field("image_height", want.image_height, hdr_if.image_height);
                check_field("pixel_offset", want.pixel_offset, hdr_if.pixel_offset);
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((byte_if.valid && byte_if.ready) || (hdr_if.valid && hdr_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, hdr_expect_q.size());
            $display("ppm_p6_header_parser_top_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = 8'h00;
        byte_if.first_byte = 1'b0;
        i_rst_n            = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed headers
        foreach (dir_cases[r]) begin
            for (int i = 0; i < dir_cases[r].text.len(); i++) begin
                put_byte(dir_cases[r].text[i], dir_cases[r].start && i == 0,
                         dir_cases[r].typed, dir_cases[r].want);
                if (i == 1)
                    repeat (dir_cases[r].pad)
                        put_byte(ppm_hdr_pkg::CHAR_SPACE, 1'b0, dir_cases[r].typed,
                                 dir_cases[r].want);
            end
            if (dir_cases[r].tail >= 0)
                put_byte(8'(dir_cases[r].tail),
                         dir_cases[r].start && dir_cases[r].text.len() == 0,
                         dir_cases[r].typed, dir_cases[r].want);
        end

        // random headers with some noise; idling swaps, then stops
        while (sent_bytes < SENT_TARGET) begin
            if (sent_bytes >= 1400) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else if (sent_bytes >= 1000) begin
                src_idle_pct  = 51;
                sink_idle_pct = 27;
            end
            if ($urandom_range(19) == 0)
                repeat ($urandom_range(1, 6))
                    put_byte(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, '0);
            else
                send_random_header();
        end
        byte_if.valid <= 1'b0;

        while (hdr_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("ppm_p6_header_parser_top_tb: done, clean");
        else
            $display("ppm_p6_header_parser_top_tb: done, errors");
        $finish;
    end

endmodule
